// ===== sv/kci_pkg.sv =====
// Package: shared constants (operation codes) for the keyframe curve interpolator.
`timescale 1ns / 1ps
package kci_pkg;
  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_EVAL  = 2'd2;
endpackage

// ===== sv/kci_ram.sv =====
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module kci_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ===== sv/kci_div.sv =====
// Serial restoring divider: signed 49-bit dividend by positive 17-bit divisor.
`timescale 1ns / 1ps
module kci_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [48:0] num_i,
  input  logic        [16:0] den_i,
  output logic               done_o,
  output logic signed [48:0] quo_o
);
  import kci_pkg::*;
  logic [48:0] rem_q, rem_d, quo_q, quo_d;
  logic [16:0] den_q, den_d;
  logic        neg_q, neg_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [49:0] trial;

  always_comb begin
    rem_d = rem_q; quo_d = quo_q; den_d = den_q; neg_d = neg_q;
    cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0;
    trial = '0;
    if (start_i) begin
      neg_d  = num_i[48];
      quo_d  = num_i[48] ? 49'(-num_i) : 49'(num_i);
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = 6'd49;
      busy_d = 1'b1;
    end else if (busy_q) begin
      trial = {rem_q, quo_q[48]} - {33'd0, den_q};
      if (!trial[49]) begin
        rem_d = trial[48:0];
        quo_d = {quo_q[47:0], 1'b1};
      end else begin
        rem_d = {rem_q[47:0], quo_q[48]};
        quo_d = {quo_q[47:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; quo_q <= quo_d; den_q <= den_d; neg_q <= neg_d;
  end

  assign done_o = done_q;
  assign quo_o  = neg_q ? -$signed(quo_q) : $signed(quo_q);
endmodule

// ===== sv/keyframe_curve_interpolator.sv =====
// Top level: keyframe table with sequential search, insert and interpolate.
`timescale 1ns / 1ps
// Usage:
//  - Input channel (in_valid_i/in_ready_o) carries one word: operation,
//    key_time, key_value. Output channel (out_valid_o/out_ready_i) returns
//    exactly one result word per input word, in order.
//  - static_value is written through cfg_we_i/cfg_wdata_i; the user must
//    write it only while idle, since the block does not enforce this.
//  - One word at a time: in_ready_o is high only in the idle state.
//  - Sequence: the search walks the key RAM one entry at a time (address,
//    then registered read). An insert then shifts the tail up, each moved
//    key taking a read, a wait and a write. An interpolation fetches the
//    left key, runs a serial multiply (one shift-add per multiplier bit)
//    and a serial divide (49 steps plus done), then loads the output
//    register. Clear and an empty-table eval go straight to the output
//    register; an eval past the last key reads that key. The key RAM port
//    and the serial units set the pace.
//  - Reset clears the key count and static_value; RAM contents stay
//    undefined and are never read beyond the key count.
//  - When the receiver stalls, the result word is held in the output
//    register; the next input word is still taken and worked on, and its
//    result waits until the output register is free.
module keyframe_curve_interpolator #(
  parameter int MAX_KEYS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic signed [31:0] cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic        [1:0]  operation_i,
  input  logic signed [15:0] key_time_i,
  input  logic signed [31:0] key_value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] curve_value_o,
  output logic               exact_key_o,
  output logic               animated_o,
  output logic               status_o
);
  import kci_pkg::*;
  localparam int AW = $clog2(MAX_KEYS);
  localparam int CW = $clog2(MAX_KEYS + 1);
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_KEYS);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD    = 4'd1;
  localparam logic [3:0] S_CMP   = 4'd2;
  localparam logic [3:0] S_SHRD  = 4'd3;
  localparam logic [3:0] S_SHWAIT= 4'd4;
  localparam logic [3:0] S_SHWR  = 4'd5;
  localparam logic [3:0] S_INS   = 4'd6;
  localparam logic [3:0] S_PREV  = 4'd7;
  localparam logic [3:0] S_PWAIT = 4'd8;
  localparam logic [3:0] S_MUL   = 4'd9;
  localparam logic [3:0] S_DIV   = 4'd10;
  localparam logic [3:0] S_DWAIT = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;
  localparam logic [3:0] S_LAST  = 4'd13;
  localparam logic [3:0] S_LWAIT = 4'd14;

  logic [3:0]  state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d, idx_q, idx_d;
  logic [1:0]  op_q, op_d;
  logic signed [15:0] t_q, t_d;
  logic signed [31:0] v_q, v_d, stat_q, stat_d;
  logic signed [15:0] t2_q, t2_d;
  logic signed [31:0] v2_q, v2_d;
  logic signed [48:0] acc_q, acc_d;
  logic [16:0] mulb_q, mulb_d;
  logic [6:0]  mcnt_q, mcnt_d;
  logic signed [32:0] mula_q, mula_d;
  logic        ovalid_q, ovalid_d;
  logic signed [31:0] cv_q, cv_d;
  logic        ex_q, ex_d, st_q, st_d;
  logic signed [31:0] ocv_q, ocv_d;
  logic        oex_q, oex_d, ost_q, ost_d, oanim_q, oanim_d;

  logic          we;
  logic [AW-1:0] addr;
  logic [47:0]   wdata, rdata;
  logic signed [15:0] rt;
  logic signed [31:0] rv;
  logic          div_start, div_done;
  logic signed [48:0] div_num, div_quo;

  kci_ram #(.Width(48), .Depth(MAX_KEYS)) u_ram (
    .clk_i(clk_i), .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rdata)
  );
  kci_div u_div (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(div_start), .num_i(div_num),
    .den_i(17'(32'(t2_q) - 32'(rt))), .done_o(div_done), .quo_o(div_quo)
  );

  assign rt = rdata[47:32];
  assign rv = rdata[31:0];
  assign div_num = acc_q;

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; idx_d = idx_q; op_d = op_q;
    t_d = t_q; v_d = v_q; stat_d = cfg_we_i ? cfg_wdata_i : stat_q;
    t2_d = t2_q; v2_d = v2_q; acc_d = acc_q; mulb_d = mulb_q;
    mcnt_d = mcnt_q; mula_d = mula_q;
    ovalid_d = ovalid_q; cv_d = cv_q; ex_d = ex_q; st_d = st_q;
    ocv_d = ocv_q; oex_d = oex_q; ost_d = ost_q; oanim_d = oanim_q;
    we = 1'b0; addr = idx_q[AW-1:0]; wdata = {t_q, v_q};
    div_start = 1'b0;
    if (ovalid_q && out_ready_i) ovalid_d = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d = operation_i; t_d = key_time_i; v_d = key_value_i;
          idx_d = '0; cv_d = '0; ex_d = 1'b0; st_d = 1'b0;
          if (operation_i == OP_CLEAR) begin
            cnt_d = '0; state_d = S_OUT;
          end else if (operation_i == OP_EVAL && cnt_q == '0) begin
            cv_d = stat_q; state_d = S_OUT;
          end else if (operation_i == OP_ADD || operation_i == OP_EVAL) begin
            state_d = S_RD;
          end else begin
            state_d = S_OUT;
          end
        end
      end
      S_RD: begin
        if (idx_q >= cnt_q) begin
          if (op_q == OP_ADD) begin
            if (cnt_q >= MaxCnt) begin
              st_d = 1'b1; state_d = S_OUT;
            end else begin
              state_d = S_INS;
            end
          end else begin
            idx_d = cnt_q - CW'(1); state_d = S_LAST;
          end
        end else begin
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        if (rt < t_q) begin
          idx_d = idx_q + CW'(1); state_d = S_RD;
        end else if (rt == t_q) begin
          ex_d = 1'b1;
          if (op_q == OP_ADD) begin
            we = 1'b1; state_d = S_OUT;
          end else begin
            cv_d = rv; state_d = S_OUT;
          end
        end else if (op_q == OP_ADD) begin
          if (cnt_q >= MaxCnt) begin
            st_d = 1'b1; state_d = S_OUT;
          end else begin
            state_d = S_SHRD;
            acc_d = 49'(cnt_q);
          end
        end else if (idx_q == '0) begin
          cv_d = rv; state_d = S_OUT;
        end else begin
          t2_d = rt; v2_d = rv; idx_d = idx_q - CW'(1); state_d = S_PREV;
        end
      end
      S_SHRD: begin
        // acc holds the destination index; move entry dst-1 to dst
        if (acc_q[CW-1:0] == idx_q) begin
          state_d = S_INS;
        end else begin
          addr = AW'(acc_q[CW-1:0] - CW'(1)); state_d = S_SHWAIT;
        end
      end
      S_SHWAIT: begin
        addr = AW'(acc_q[CW-1:0] - CW'(1)); state_d = S_SHWR;
      end
      S_SHWR: begin
        addr = acc_q[AW-1:0]; we = 1'b1; wdata = rdata;
        acc_d = acc_q - 49'd1; state_d = S_SHRD;
      end
      S_INS: begin
        we = 1'b1; cnt_d = cnt_q + CW'(1); ex_d = 1'b1; state_d = S_OUT;
      end
      S_PREV: state_d = S_PWAIT;
      S_PWAIT: begin
        mula_d = 33'(v2_q) - 33'(rv);
        mulb_d = 17'(32'(t_q) - 32'(rt));
        acc_d = '0; mcnt_d = 7'd17; v_d = rv; state_d = S_MUL;
      end
      S_MUL: begin
        // shift-add multiply, one multiplier bit per cycle
        acc_d = (acc_q <<< 1) + (mulb_q[16] ? 49'(mula_q) : 49'd0);
        mulb_d = {mulb_q[15:0], 1'b0};
        mcnt_d = mcnt_q - 7'd1;
        if (mcnt_q == 7'd1) state_d = S_DIV;
      end
      S_DIV: begin
        div_start = 1'b1; state_d = S_DWAIT;
      end
      S_DWAIT: begin
        if (div_done) begin
          cv_d = v_q + div_quo[31:0]; state_d = S_OUT;
        end
      end
      S_LAST: state_d = S_LWAIT;
      S_LWAIT: begin
        cv_d = rv; state_d = S_OUT;
      end
      S_OUT: begin
        // wait here while the previous word is still held
        if (!ovalid_q || out_ready_i) begin
          ovalid_d = 1'b1; ocv_d = cv_q; oex_d = ex_q; ost_d = st_q;
          oanim_d = cnt_q != '0; state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; cnt_q <= '0; ovalid_q <= 1'b0; stat_q <= '0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; ovalid_q <= ovalid_d; stat_q <= stat_d;
    end
  end
  always_ff @(posedge clk_i) begin
    idx_q <= idx_d; op_q <= op_d; t_q <= t_d; v_q <= v_d; t2_q <= t2_d;
    v2_q <= v2_d; acc_q <= acc_d; mulb_q <= mulb_d; mcnt_q <= mcnt_d;
    mula_q <= mula_d; cv_q <= cv_d; ex_q <= ex_d; st_q <= st_d;
    ocv_q <= ocv_d; oex_q <= oex_d; ost_q <= ost_d; oanim_q <= oanim_d;
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = ovalid_q;
  assign curve_value_o = ocv_q;
  assign exact_key_o   = oex_q;
  assign animated_o    = oanim_q;
  assign status_o      = ost_q;
endmodule

// ===== sv/kci_checker.sv =====
// Port-level checker for the keyframe curve interpolator, with bind.
`timescale 1ns / 1ps
module kci_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic exact_key_o,
  input logic animated_o,
  input logic status_o,
  input logic signed [31:0] curve_value_o
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(curve_value_o))
    else $error("result word changed under stall");
  a_flaghold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(exact_key_o) && $stable(status_o)
      && $stable(animated_o))
    else $error("result flags changed under stall");
  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready right after accept");
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(exact_key_o && status_o))
    else $error("exact and full together");
  a_fullanim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> animated_o)
    else $error("full table without keys");
endmodule

bind keyframe_curve_interpolator kci_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
  .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .exact_key_o(exact_key_o),
  .animated_o(animated_o), .status_o(status_o), .curve_value_o(curve_value_o)
);
